// ----- rtl/scfr_pkg.sv -----
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants for the sum-checked frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

    // Frame layout
    localparam logic [7:0] HDR_BYTE  = 8'hA5;
    localparam logic [7:0] SPEED_CMD = 8'h02;
    localparam int         FRAME_LEN = 7;
    localparam int         SUM_LEN   = 6;
    localparam int         CNT_W     = $clog2(FRAME_LEN);

    // Reported frame status
    typedef enum logic [1:0] {
        ST_SPEED   = 2'd0,
        ST_OTHER   = 2'd1,
        ST_SUM_ERR = 2'd2,
        ST_HDR_ERR = 2'd3
    } t_status;

    // One decoded frame result
    typedef struct packed {
        t_status            status;
        logic        [7:0]  command_code;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
    } t_result;

endpackage

// ----- rtl/scfr_frame_check.sv -----
// ----------------------------------------------------------------------------
// scfr_frame_check
// Classifies a completed frame: header and checksum test, command decode,
// big-endian speed extraction.
// ----------------------------------------------------------------------------
module scfr_frame_check (
    input  logic [7:0]        i_hdr,
    input  logic [7:0]        i_cmd,
    input  logic [7:0]        i_d2,
    input  logic [7:0]        i_d3,
    input  logic [7:0]        i_d4,
    input  logic [7:0]        i_d5,
    input  logic [7:0]        i_sum,
    input  logic [7:0]        i_check,
    output scfr_pkg::t_result o_result
);

    // Status priority: header, checksum, command
    always_comb begin
        o_result              = '0;
        o_result.command_code = i_cmd;
        if (i_hdr != scfr_pkg::HDR_BYTE) begin
            o_result.status = scfr_pkg::ST_HDR_ERR;
        end else if (i_sum != i_check) begin
            o_result.status = scfr_pkg::ST_SUM_ERR;
        end else if (i_cmd == scfr_pkg::SPEED_CMD) begin
            o_result.status      = scfr_pkg::ST_SPEED;
            o_result.left_speed  = {i_d2, i_d3};
            o_result.right_speed = {i_d4, i_d5};
        end else begin
            o_result.status = scfr_pkg::ST_OTHER;
        end
    end

endmodule

// ----- rtl/sum_checked_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver
// Gathers received bytes into 7-byte header/command/data/sum frames and
// reports one status item per completed frame.
// ----------------------------------------------------------------------------
// Result: registered; a frame's result is valid in the cycle after its seventh byte is accepted.
// Throughput: one byte per cycle; a running sum and a byte counter do the
//   frame work, so only the output register can stall the input.
// Reset: i_rst_n synchronous, active low; clears the byte count, running sum
//   and output valid, so a new frame starts at position zero.
module sum_checked_frame_receiver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_frame_status,
    output logic [7:0]         o_command_code,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed
);

    localparam int CW = scfr_pkg::CNT_W;
    localparam logic [CW-1:0] LAST_POS = CW'(scfr_pkg::SUM_LEN);

    // Frame storage: bytes zero to five; the check byte is the live input
    logic [7:0]        r_bytes [scfr_pkg::SUM_LEN];
    logic [CW-1:0]     r_count, n_count;
    logic [7:0]        r_sum, n_sum;
    logic              r_out_valid;
    scfr_pkg::t_result r_result;

    logic              in_acc;
    logic              restart;
    logic [CW-1:0]     eff_count;
    logic [7:0]        eff_sum;
    logic              complete;
    scfr_pkg::t_result chk_result;

    // Input stalls only when a frame may finish into a full, blocked output
    assign o_in_ready = !(r_out_valid && !i_out_ready && (r_count == LAST_POS));
    assign in_acc     = i_in_valid && o_in_ready;

    // A header byte restarts collection unless byte zero is already a header
    assign restart   = (i_rx_byte == scfr_pkg::HDR_BYTE) && (r_bytes[0] != scfr_pkg::HDR_BYTE);
    assign eff_count = restart ? '0 : r_count;
    assign eff_sum   = restart ? '0 : r_sum;
    assign complete  = (eff_count == LAST_POS);

    always_comb begin
        n_count = eff_count + CW'(1);
        n_sum   = eff_sum + i_rx_byte;
        if (complete) begin
            n_count = '0;
            n_sum   = '0;
        end
    end

    scfr_frame_check u_check (
        .i_hdr    (r_bytes[0]),
        .i_cmd    (r_bytes[1]),
        .i_d2     (r_bytes[2]),
        .i_d3     (r_bytes[3]),
        .i_d4     (r_bytes[4]),
        .i_d5     (r_bytes[5]),
        .i_sum    (r_sum),
        .i_check  (i_rx_byte),
        .o_result (chk_result)
    );

    // Counter and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (in_acc) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Byte store
    always_ff @(posedge i_clk) begin
        if (in_acc && !complete) begin
            r_bytes[eff_count] <= i_rx_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && complete) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && complete) begin
            r_result <= chk_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_result.status;
    assign o_command_code = r_result.command_code;
    assign o_left_speed   = r_result.left_speed;
    assign o_right_speed  = r_result.right_speed;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_POS)
        else $error("byte count out of range");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && complete) |=> o_out_valid)
        else $error("completed frame produced no result");

    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && r_count == LAST_POS))
        else $error("input stalled without a blocked output");

    a_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_status != scfr_pkg::ST_SPEED)
            |-> (o_left_speed == 16'sd0 && o_right_speed == 16'sd0))
        else $error("speeds nonzero on a non-speed status");

endmodule
